// ===== hdl/mialu_pkg.sv =====
// Package for the MIPS integer ALU block: widths, opcodes, function codes,
// status codes and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mialu_pkg;

   localparam int DataWidth   = 32;
   localparam int RegCount    = 32;
   localparam int RegIdxWidth = 5;

   typedef logic [5:0]             opcode_type;
   typedef logic [5:0]             funct_type;
   typedef logic [RegIdxWidth-1:0] reg_idx_type;
   typedef logic [DataWidth-1:0]   word_type;

   // Primary opcodes
   localparam opcode_type OP_RTYPE = 6'd0;
   localparam opcode_type OP_ADDI  = 6'd8;
   localparam opcode_type OP_ADDIU = 6'd9;
   localparam opcode_type OP_SLTI  = 6'd10;
   localparam opcode_type OP_SLTIU = 6'd11;

   // R-type function codes
   localparam funct_type FN_SLL  = 6'd0;
   localparam funct_type FN_SRL  = 6'd2;
   localparam funct_type FN_SRA  = 6'd3;
   localparam funct_type FN_SLLV = 6'd4;
   localparam funct_type FN_SRLV = 6'd6;
   localparam funct_type FN_ADD  = 6'd32;
   localparam funct_type FN_ADDU = 6'd33;
   localparam funct_type FN_SUB  = 6'd34;
   localparam funct_type FN_SUBU = 6'd35;
   localparam funct_type FN_AND  = 6'd36;
   localparam funct_type FN_OR   = 6'd37;
   localparam funct_type FN_XOR  = 6'd38;
   localparam funct_type FN_SLT  = 6'd42;
   localparam funct_type FN_SLTU = 6'd43;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_OPCODE = 2'd1,
      STATUS_BAD_FUNCT  = 2'd2
   } status_type;

   typedef struct packed {
      logic        write_done;
      reg_idx_type written_reg;
      word_type    written_value;
      status_type  status;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/mialu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mialu_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/mialu_exec.sv =====
// Combinational execute unit: decodes opcode and function code and forms
// the result record from the two operands. Depends on mialu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mialu_exec (
   input  wire  mialu_pkg::opcode_type  mode,
   input  wire  mialu_pkg::reg_idx_type target_reg,
   input  wire  mialu_pkg::reg_idx_type dest_reg,
   input  wire  logic [4:0]             shift_amount,
   input  wire  mialu_pkg::funct_type   function_code,
   input  wire  logic [15:0]            immediate,
   input  wire  mialu_pkg::word_type    rs_value,
   input  wire  mialu_pkg::word_type    rt_value,
   output mialu_pkg::result_type        result
);
   import mialu_pkg::*;

   word_type   simm;
   word_type   val;
   reg_idx_type dst;
   status_type status;

   assign simm = {{(DataWidth-16){immediate[15]}}, immediate};

   always_comb begin
      val    = '0;
      dst    = '0;
      status = STATUS_OK;
      if (mode == OP_RTYPE) begin
         dst = dest_reg;
         case (function_code)
            FN_SLL:          val = rt_value << shift_amount;
            FN_SRL:          val = rt_value >> shift_amount;
            FN_SRA:          val = word_type'($signed(rt_value) >>> shift_amount);
            FN_SLLV:         val = rt_value << rs_value[4:0];
            FN_SRLV:         val = rt_value >> rs_value[4:0];
            FN_ADD, FN_ADDU: val = rs_value + rt_value;
            FN_SUB, FN_SUBU: val = rs_value - rt_value;
            FN_AND:          val = rs_value & rt_value;
            FN_OR:           val = rs_value | rt_value;
            FN_XOR:          val = rs_value ^ rt_value;
            FN_SLT:          val = word_type'($signed(rs_value) < $signed(rt_value));
            FN_SLTU:         val = word_type'(rs_value < rt_value);
            default:         status = STATUS_BAD_FUNCT;
         endcase
      end else begin
         dst = target_reg;
         case (mode)
            OP_ADDI, OP_ADDIU: val = rs_value + simm;
            OP_SLTI:           val = word_type'($signed(rs_value) < $signed(simm));
            OP_SLTIU:          val = word_type'(rs_value < simm);
            default:           status = STATUS_BAD_OPCODE;
         endcase
      end

      if (status != STATUS_OK) begin
         result.write_done    = 1'b0;
         result.written_reg   = '0;
         result.written_value = '0;
      end else begin
         result.write_done    = 1'b1;
         result.written_reg   = dst;
         result.written_value = val;
      end
      result.status = status;
   end

endmodule
`default_nettype wire

// ===== hdl/mips_integer_alu_with_register_file.sv =====
// Top level: MIPS integer ALU subset with a 32 x 32 register file.
// Depends on mialu_pkg, mialu_ram and mialu_exec.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mode, regs, shift, function, immediate
//   rsp      out        rsp_valid/stall    write_done, written_reg/value, status
//
// One request per cycle while rsp_stall is low; rsp_valid rises after acceptance
// (register file read into the execute stage, then execute into the result register).
// Reset clears the register file at once through per-entry valid bits.
// A stalled result holds the execute stage; a request is still taken while
// the execute stage is empty or moving into the result register.
// A write in the same cycle as a read is forwarded from the write-back register.
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_alu_with_register_file (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   req_valid,
   output logic                         req_stall,
   input  wire  mialu_pkg::opcode_type  req_mode,
   input  wire  mialu_pkg::reg_idx_type req_source_reg,
   input  wire  mialu_pkg::reg_idx_type req_target_reg,
   input  wire  mialu_pkg::reg_idx_type req_dest_reg,
   input  wire  logic [4:0]             req_shift_amount,
   input  wire  mialu_pkg::funct_type   req_function_code,
   input  wire  logic [15:0]            req_immediate,
   output logic                         rsp_valid,
   input  wire  logic                   rsp_stall,
   output logic                         rsp_write_done,
   output mialu_pkg::reg_idx_type       rsp_written_reg,
   output mialu_pkg::word_type          rsp_written_value,
   output logic [1:0]                   rsp_status
);
   import mialu_pkg::*;

   logic        req_accept;
   logic        ex_advance;

   // execute stage
   logic        ex_valid_ff,  ex_valid_in;
   opcode_type  ex_mode_ff;
   reg_idx_type ex_source_ff;
   reg_idx_type ex_target_ff;
   reg_idx_type ex_dest_ff;
   logic [4:0]  ex_shift_ff;
   funct_type   ex_funct_ff;
   logic [15:0] ex_imm_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;

   // register file bookkeeping
   logic [RegCount-1:0] reg_valid_ff, reg_valid_in;
   logic        wb_valid_ff;
   reg_idx_type wb_idx_ff;
   word_type    wb_data_ff;

   word_type    rs_ram, rt_ram;
   word_type    rs_value, rt_value;
   result_type  ex_result;
   logic        rf_wr_en;

   function automatic word_type read_operand(
      input reg_idx_type         idx,
      input word_type            ram_data,
      input logic [RegCount-1:0] valid,
      input logic                fwd_valid,
      input reg_idx_type         fwd_idx,
      input word_type            fwd_data
   );
      word_type value;
      if (idx == '0) begin
         value = '0;
      end else if (fwd_valid && fwd_idx == idx) begin
         value = fwd_data;
      end else if (valid[idx]) begin
         value = ram_data;
      end else begin
         value = '0;
      end
      return value;
   endfunction

   assign ex_advance = ex_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = ex_valid_ff && !ex_advance;
   assign req_accept = req_valid && !req_stall;

   assign rf_wr_en = ex_advance && ex_result.write_done && (ex_result.written_reg != '0);

   mialu_ram #(
      .Width (DataWidth),
      .Depth (RegCount)
   ) u_rf_rs (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (ex_result.written_reg),
      .wr_data (ex_result.written_value),
      .rd_en   (req_accept),
      .rd_addr (req_source_reg),
      .rd_data (rs_ram)
   );

   mialu_ram #(
      .Width (DataWidth),
      .Depth (RegCount)
   ) u_rf_rt (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (ex_result.written_reg),
      .wr_data (ex_result.written_value),
      .rd_en   (req_accept),
      .rd_addr (req_target_reg),
      .rd_data (rt_ram)
   );

   assign rs_value = read_operand(ex_source_ff, rs_ram, reg_valid_ff,
                                  wb_valid_ff, wb_idx_ff, wb_data_ff);
   assign rt_value = read_operand(ex_target_ff, rt_ram, reg_valid_ff,
                                  wb_valid_ff, wb_idx_ff, wb_data_ff);

   mialu_exec u_exec (
      .mode          (ex_mode_ff),
      .target_reg    (ex_target_ff),
      .dest_reg      (ex_dest_ff),
      .shift_amount  (ex_shift_ff),
      .function_code (ex_funct_ff),
      .immediate     (ex_imm_ff),
      .rs_value      (rs_value),
      .rt_value      (rt_value),
      .result        (ex_result)
   );

   always_comb begin
      ex_valid_in  = req_accept || (ex_valid_ff && !ex_advance);
      rsp_valid_in = ex_advance || (rsp_valid_ff && rsp_stall);
      reg_valid_in = reg_valid_ff;
      if (rf_wr_en) begin
         reg_valid_in[ex_result.written_reg] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_valid_ff <= '0;
         wb_valid_ff  <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_valid_ff <= reg_valid_in;
         if (rf_wr_en) begin
            wb_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ex_mode_ff   <= req_mode;
         ex_source_ff <= req_source_reg;
         ex_target_ff <= req_target_reg;
         ex_dest_ff   <= req_dest_reg;
         ex_shift_ff  <= req_shift_amount;
         ex_funct_ff  <= req_function_code;
         ex_imm_ff    <= req_immediate;
      end
      if (ex_advance) begin
         rsp_ff <= ex_result;
      end
      if (rf_wr_en) begin
         wb_idx_ff  <= ex_result.written_reg;
         wb_data_ff <= ex_result.written_value;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_done    = rsp_ff.write_done;
   assign rsp_written_reg   = rsp_ff.written_reg;
   assign rsp_written_value = rsp_ff.written_value;
   assign rsp_status        = rsp_ff.status;

`ifndef SYNTHESIS
   a_no_write_reg0: assert property (@(posedge clock) disable iff (reset)
      rf_wr_en |-> ex_result.written_reg != '0)
      else $error("register zero written");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ex_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked item");

   a_error_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |-> !rsp_ff.write_done)
      else $error("failed request reports a write");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid_ff && !ex_valid_ff && reg_valid_ff == '0)
      else $error("pipeline or register file not cleared by reset");

   a_wb_tracks_write: assert property (@(posedge clock) disable iff (reset)
      rf_wr_en |=> wb_valid_ff && reg_valid_ff[wb_idx_ff])
      else $error("write-back register out of step with valid bits");
`endif

endmodule
`default_nettype wire
